@@ rtl/gicm_pkg.sv @@
package gicm_pkg;

  localparam int MAX_REGIONS_DEF = 8;
  localparam int ENTRY_SLOTS_DEF = 256;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;
  localparam int ACTIVE_W = 4;

  localparam logic [CFG_AW-1:0] REG_ACTIVE_REGIONS = '0;

  localparam logic [15:0] NO_CODE = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_HDR_WR = 2'd0,
    KIND_SLOT_WR = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    METHOD_DIRECT = 2'd0,
    METHOD_TABLE = 2'd1,
    METHOD_SCAN = 2'd2,
    METHOD_NONE = 2'd3
  } method_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [15:0] first_code;
    logic [15:0] last_code;
    logic [1:0] mode;
    logic [15:0] index_offset;
    logic [7:0] slot_base;
    logic [8:0] slot_count;
  } hdr_t;

  typedef struct packed {
    logic [15:0] glyph;
    logic [15:0] code;
  } slot_t;

endpackage

@@ rtl/gicm_ram.sv @@
module gicm_ram #(
  parameter int DEPTH = 8,
  parameter int AW = 3,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/gicm_ctrl.sv @@
module gicm_ctrl #(
  parameter int MAX_REGIONS = gicm_pkg::MAX_REGIONS_DEF,
  parameter int ENTRY_SLOTS = gicm_pkg::ENTRY_SLOTS_DEF,
  parameter int RGN_AW = 3,
  parameter int SLOT_AW = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_kind,
  input  logic [2:0]                      in_region,
  input  logic [15:0]                     in_code_begin,
  input  logic [15:0]                     in_code_end,
  input  logic [1:0]                      in_method,
  input  logic [15:0]                     in_direct_offset,
  input  logic [7:0]                      in_entry_base,
  input  logic [8:0]                      in_entry_count,
  input  logic [7:0]                      in_entry_slot,
  input  logic [15:0]                     in_entry_code,
  input  logic [15:0]                     in_glyph_index,
  input  logic [gicm_pkg::ACTIVE_W-1:0]   active_regions,
  output logic                            hdr_we,
  output logic [RGN_AW-1:0]               hdr_waddr,
  output gicm_pkg::hdr_t                  hdr_wdata,
  output logic                            hdr_re,
  output logic [RGN_AW-1:0]               hdr_raddr,
  input  gicm_pkg::hdr_t                  hdr_rdata,
  output logic                            slot_we,
  output logic [SLOT_AW-1:0]              slot_waddr,
  output gicm_pkg::slot_t                 slot_wdata,
  output logic                            slot_re,
  output logic [SLOT_AW-1:0]              slot_raddr,
  input  gicm_pkg::slot_t                 slot_rdata,
  output logic                            out_valid,
  output logic [15:0]                     out_code_point,
  output logic                            out_found
);

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  gicm_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] rgn_r, rgn_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [15:0] glyph_r, glyph_nxt;
  logic [8:0] p_r, p_nxt;
  logic cmp_valid_r, cmp_valid_nxt;
  logic [8:0] cmp_p_r, cmp_p_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [15:0] out_code_r, out_code_nxt;
  logic out_found_r, out_found_nxt;

  logic [CNT_W-1:0] n_clamp;
  logic [CNT_W-1:0] rgn_inc;
  logic last_rgn;
  logic [17:0] direct_lim;
  logic direct_hit;
  logic [15:0] direct_code;
  logic [8:0] p_issue;
  logic [9:0] scan_sum;
  logic scan_in_range;
  logic slot_match;
  logic [15:0] slot_code;

  always_comb begin
    if ({{(32-gicm_pkg::ACTIVE_W){1'b0}}, active_regions} > MAX_REGIONS) begin
      n_clamp = CNT_W'(MAX_REGIONS);
    end else begin
      n_clamp = CNT_W'(active_regions);
    end
  end

  assign rgn_inc = rgn_r + CNT_W'(1);
  assign last_rgn = (rgn_inc == n_r);

  // The upper end of a direct region is signed, so an inverted range never matches.
  assign direct_lim = {2'b00, hdr_rdata.last_code} - {2'b00, hdr_rdata.first_code}
                    + {2'b00, hdr_rdata.index_offset};
  assign direct_hit = (glyph_r >= hdr_rdata.index_offset)
                    && !($signed({2'b00, glyph_r}) > $signed(direct_lim));
  assign direct_code = hdr_rdata.first_code + glyph_r - hdr_rdata.index_offset;

  assign p_issue = (state_r == gicm_pkg::ST_HDR) ? 9'd0 : p_r;
  assign scan_sum = {2'b00, hdr_rdata.slot_base} + {1'b0, p_issue};
  assign scan_in_range = ({22'b0, scan_sum} < ENTRY_SLOTS);

  assign slot_match = cmp_valid_r && (slot_rdata.glyph == glyph_r);
  assign slot_code = (hdr_rdata.mode == gicm_pkg::METHOD_TABLE)
                   ? hdr_rdata.first_code + {7'b0, cmp_p_r}
                   : slot_rdata.code;

  assign hdr_waddr = RGN_AW'(in_region);
  assign hdr_wdata = '{first_code: in_code_begin, last_code: in_code_end, mode: in_method,
                       index_offset: in_direct_offset, slot_base: in_entry_base,
                       slot_count: in_entry_count};
  assign slot_waddr = SLOT_AW'(in_entry_slot);
  assign slot_wdata = '{glyph: in_glyph_index, code: in_entry_code};
  assign slot_raddr = SLOT_AW'(scan_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gicm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cmp_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_valid_r <= cmp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rgn_r <= rgn_nxt;
    n_r <= n_nxt;
    glyph_r <= glyph_nxt;
    p_r <= p_nxt;
    cmp_p_r <= cmp_p_nxt;
    out_code_r <= out_code_nxt;
    out_found_r <= out_found_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    rgn_nxt = rgn_r;
    n_nxt = n_r;
    glyph_nxt = glyph_r;
    p_nxt = p_r;
    cmp_valid_nxt = 1'b0;
    cmp_p_nxt = cmp_p_r;
    out_valid_nxt = 1'b0;
    out_code_nxt = out_code_r;
    out_found_nxt = out_found_r;
    hdr_we = 1'b0;
    hdr_re = 1'b0;
    hdr_raddr = RGN_AW'(rgn_inc);
    slot_we = 1'b0;
    slot_re = 1'b0;

    case (state_r)
      gicm_pkg::ST_IDLE: begin
        if (start) begin
          case (gicm_pkg::kind_t'(in_kind))
            gicm_pkg::KIND_HDR_WR: begin
              hdr_we = ({29'b0, in_region} < MAX_REGIONS);
            end
            gicm_pkg::KIND_SLOT_WR: begin
              slot_we = ({24'b0, in_entry_slot} < ENTRY_SLOTS);
            end
            gicm_pkg::KIND_LOOKUP: begin
              glyph_nxt = in_glyph_index;
              rgn_nxt = '0;
              n_nxt = n_clamp;
              if (n_clamp == '0) begin
                out_valid_nxt = 1'b1;
                out_code_nxt = gicm_pkg::NO_CODE;
                out_found_nxt = 1'b0;
              end else begin
                hdr_re = 1'b1;
                hdr_raddr = '0;
                state_nxt = gicm_pkg::ST_HDR;
              end
            end
            default: begin
            end
          endcase
        end
      end

      gicm_pkg::ST_HDR: begin
        if (hdr_rdata.mode == gicm_pkg::METHOD_DIRECT && direct_hit
            && direct_code != gicm_pkg::NO_CODE) begin
          out_valid_nxt = 1'b1;
          out_code_nxt = direct_code;
          out_found_nxt = 1'b1;
          state_nxt = gicm_pkg::ST_IDLE;
        end else if ((hdr_rdata.mode == gicm_pkg::METHOD_TABLE
                      || hdr_rdata.mode == gicm_pkg::METHOD_SCAN)
                     && hdr_rdata.slot_count != 9'd0) begin
          slot_re = scan_in_range;
          cmp_valid_nxt = scan_in_range;
          cmp_p_nxt = 9'd0;
          p_nxt = 9'd1;
          state_nxt = gicm_pkg::ST_SCAN;
        end else if (last_rgn) begin
          out_valid_nxt = 1'b1;
          out_code_nxt = gicm_pkg::NO_CODE;
          out_found_nxt = 1'b0;
          state_nxt = gicm_pkg::ST_IDLE;
        end else begin
          rgn_nxt = rgn_inc;
          hdr_re = 1'b1;
        end
      end

      gicm_pkg::ST_SCAN: begin
        // Each cycle checks the slot read in the cycle before and issues the next one.
        // A match whose code is the no-code value ends this region only.
        if (slot_match && slot_code != gicm_pkg::NO_CODE) begin
          out_valid_nxt = 1'b1;
          out_code_nxt = slot_code;
          out_found_nxt = 1'b1;
          state_nxt = gicm_pkg::ST_IDLE;
        end else if (slot_match || p_r == hdr_rdata.slot_count) begin
          if (last_rgn) begin
            out_valid_nxt = 1'b1;
            out_code_nxt = gicm_pkg::NO_CODE;
            out_found_nxt = 1'b0;
            state_nxt = gicm_pkg::ST_IDLE;
          end else begin
            rgn_nxt = rgn_inc;
            hdr_re = 1'b1;
            state_nxt = gicm_pkg::ST_HDR;
          end
        end else begin
          slot_re = scan_in_range;
          cmp_valid_nxt = scan_in_range;
          cmp_p_nxt = p_r;
          p_nxt = p_r + 9'd1;
        end
      end

      default: begin
        state_nxt = gicm_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != gicm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_code_point = out_code_r;
  assign out_found = out_found_r;

endmodule

@@ rtl/glyph_index_to_code_point_map.sv @@
// Reverse character map: header requests (kind 0) and entry requests (kind 1) are taken in one
// cycle each; a lookup request (kind 2) reads the region headers one per cycle from a small
// memory and walks the slots of a table or scan region one per cycle through the entry memory.
// A lookup keeps busy high for the sum, over the regions it tries, of one cycle for a direct
// region or an unknown method and one plus the slot count for a table or scan region; it stops at
// the first hit. The result comes on out_valid for a single cycle, the one after busy falls, and
// cannot be held off, so the receiver must take it then. Other requests give no result.
// active_regions is written through the register port and should only change while busy is low.
module glyph_index_to_code_point_map #(
  parameter int MAX_REGIONS = gicm_pkg::MAX_REGIONS_DEF,
  parameter int ENTRY_SLOTS = gicm_pkg::ENTRY_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic [2:0]                    in_region,
  input  logic [15:0]                   in_code_begin,
  input  logic [15:0]                   in_code_end,
  input  logic [1:0]                    in_method,
  input  logic [15:0]                   in_direct_offset,
  input  logic [7:0]                    in_entry_base,
  input  logic [8:0]                    in_entry_count,
  input  logic [7:0]                    in_entry_slot,
  input  logic [15:0]                   in_entry_code,
  input  logic [15:0]                   in_glyph_index,
  output logic                          out_valid,
  output logic [15:0]                   out_code_point,
  output logic                          out_found,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gicm_pkg::CFG_AW-1:0]   paddr,
  input  logic [gicm_pkg::CFG_DW-1:0]   pwdata,
  output logic [gicm_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int RGN_AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int SLOT_AW = $clog2(ENTRY_SLOTS);

  logic [gicm_pkg::ACTIVE_W-1:0] active_r;

  logic hdr_we, hdr_re;
  logic [RGN_AW-1:0] hdr_waddr, hdr_raddr;
  gicm_pkg::hdr_t hdr_wdata, hdr_rdata;
  logic slot_we, slot_re;
  logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
  gicm_pkg::slot_t slot_wdata, slot_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr == gicm_pkg::REG_ACTIVE_REGIONS) begin
      active_r <= pwdata[gicm_pkg::ACTIVE_W-1:0];
    end
  end

  assign prdata = (paddr == gicm_pkg::REG_ACTIVE_REGIONS)
                ? {{(gicm_pkg::CFG_DW-gicm_pkg::ACTIVE_W){1'b0}}, active_r}
                : '0;

  gicm_ram #(
    .DEPTH(MAX_REGIONS),
    .AW(RGN_AW),
    .DW($bits(gicm_pkg::hdr_t))
  ) u_hdr_ram (
    .clk(clk),
    .we(hdr_we),
    .waddr(hdr_waddr),
    .wdata(hdr_wdata),
    .re(hdr_re),
    .raddr(hdr_raddr),
    .rdata(hdr_rdata)
  );

  gicm_ram #(
    .DEPTH(ENTRY_SLOTS),
    .AW(SLOT_AW),
    .DW($bits(gicm_pkg::slot_t))
  ) u_slot_ram (
    .clk(clk),
    .we(slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wdata),
    .re(slot_re),
    .raddr(slot_raddr),
    .rdata(slot_rdata)
  );

  gicm_ctrl #(
    .MAX_REGIONS(MAX_REGIONS),
    .ENTRY_SLOTS(ENTRY_SLOTS),
    .RGN_AW(RGN_AW),
    .SLOT_AW(SLOT_AW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_region(in_region),
    .in_code_begin(in_code_begin),
    .in_code_end(in_code_end),
    .in_method(in_method),
    .in_direct_offset(in_direct_offset),
    .in_entry_base(in_entry_base),
    .in_entry_count(in_entry_count),
    .in_entry_slot(in_entry_slot),
    .in_entry_code(in_entry_code),
    .in_glyph_index(in_glyph_index),
    .active_regions(active_r),
    .hdr_we(hdr_we),
    .hdr_waddr(hdr_waddr),
    .hdr_wdata(hdr_wdata),
    .hdr_re(hdr_re),
    .hdr_raddr(hdr_raddr),
    .hdr_rdata(hdr_rdata),
    .slot_we(slot_we),
    .slot_waddr(slot_waddr),
    .slot_wdata(slot_wdata),
    .slot_re(slot_re),
    .slot_raddr(slot_raddr),
    .slot_rdata(slot_rdata),
    .out_valid(out_valid),
    .out_code_point(out_code_point),
    .out_found(out_found)
  );

endmodule
